/* rtl/core/tac_pkg.sv */
`default_nettype none

package tac_pkg;

   localparam int ROM_SIZE          = 20;
   localparam int IDX_W             = 5;
   localparam int ADC_W             = 10;
   localparam int TEMP_W            = 8;
   localparam int CEL_W             = 10;
   localparam int ROM_ADC_BASE      = 1;
   localparam int ROM_STEP          = 53;
   localparam int RESET_TEMPERATURE = 21;
   localparam int TEMP_MAX          = 255;

   // offset of the average from the lower segment entry: -1..52
   localparam int OFFSET_W          = 7;
   localparam int MAG_W             = 6;

   // |offset * slope| stays below 2^15 for this table
   localparam int SEG_PROD_W        = 15;
   localparam int STEP_DIV_SHIFT    = SEG_PROD_W + $clog2(ROM_STEP);
   localparam int STEP_RECIP        = ((1 << STEP_DIV_SHIFT) + ROM_STEP - 1) / ROM_STEP;
   localparam int COEF_W            = 25;
   localparam int INTERP_W          = 12;

   typedef struct packed {
      logic                       hit;
      logic [IDX_W-1:0]           idx;
      logic signed [OFFSET_W-1:0] offset;
   } seg_type;

   function automatic logic [ADC_W-1:0] rom_adc(input logic [IDX_W-1:0] idx);
      return ADC_W'(ROM_ADC_BASE + ROM_STEP * int'(idx));
   endfunction

   function automatic logic [CEL_W-1:0] rom_celsius(input logic [IDX_W-1:0] idx);
      logic [CEL_W-1:0] c;
      case (idx)
         5'd0: begin
            c = 10'd841;
         end
         5'd1: begin
            c = 10'd255;
         end
         5'd2: begin
            c = 10'd209;
         end
         5'd3: begin
            c = 10'd184;
         end
         5'd4: begin
            c = 10'd166;
         end
         5'd5: begin
            c = 10'd153;
         end
         5'd6: begin
            c = 10'd142;
         end
         5'd7: begin
            c = 10'd132;
         end
         5'd8: begin
            c = 10'd124;
         end
         5'd9: begin
            c = 10'd116;
         end
         5'd10: begin
            c = 10'd108;
         end
         5'd11: begin
            c = 10'd101;
         end
         5'd12: begin
            c = 10'd93;
         end
         5'd13: begin
            c = 10'd86;
         end
         5'd14: begin
            c = 10'd78;
         end
         5'd15: begin
            c = 10'd70;
         end
         5'd16: begin
            c = 10'd61;
         end
         5'd17: begin
            c = 10'd50;
         end
         5'd18: begin
            c = 10'd34;
         end
         5'd19: begin
            c = 10'd3;
         end
         default: begin
            c = '0;
         end
      endcase
      return c;
   endfunction

   function automatic logic seg_falling(input logic [IDX_W-1:0] idx);
      return rom_celsius(idx) < rom_celsius(idx - IDX_W'(1));
   endfunction

   // |slope| premultiplied by the reciprocal of the step
   function automatic logic [COEF_W-1:0] seg_coef(input logic [IDX_W-1:0] idx);
      int dy;
      dy = int'(rom_celsius(idx)) - int'(rom_celsius(idx - IDX_W'(1)));
      if (dy < 0) begin
         dy = -dy;
      end
      return COEF_W'(dy * STEP_RECIP);
   endfunction

endpackage

`default_nettype wire

/* rtl/core/tac_segment.sv */
`default_nettype none

module tac_segment #(
   parameter int TABLE_USED = 20
) (
   input  wire logic [tac_pkg::ADC_W-1:0] avg,
   output tac_pkg::seg_type               seg
);

   localparam int IDX_W    = tac_pkg::IDX_W;
   localparam int OFFSET_W = tac_pkg::OFFSET_W;

   always_comb begin
      seg.hit    = 1'b0;
      seg.idx    = IDX_W'(TABLE_USED - 1);
      seg.offset = '0;
      for (int i = TABLE_USED - 1; i >= 1; i--) begin
         if (tac_pkg::rom_adc(IDX_W'(i)) > avg) begin
            seg.hit = 1'b1;
            seg.idx = IDX_W'(i);
         end
      end
      if (seg.hit) begin
         seg.offset = OFFSET_W'($signed({1'b0, avg})
                    - $signed({1'b0, tac_pkg::rom_adc(seg.idx - IDX_W'(1))}));
      end
   end

endmodule

`default_nettype wire

/* rtl/core/tac_interp.sv */
`default_nettype none

module tac_interp #(
   parameter int TABLE_USED = 20
) (
   input  wire tac_pkg::seg_type           seg,
   output logic [tac_pkg::TEMP_W-1:0]      temp
);

   localparam int IDX_W    = tac_pkg::IDX_W;
   localparam int OFFSET_W = tac_pkg::OFFSET_W;
   localparam int MAG_W    = tac_pkg::MAG_W;
   localparam int COEF_W   = tac_pkg::COEF_W;
   localparam int CEL_W    = tac_pkg::CEL_W;
   localparam int INTERP_W = tac_pkg::INTERP_W;
   localparam int TEMP_W   = tac_pkg::TEMP_W;
   localparam int MUL_W    = COEF_W + MAG_W;

   logic [MAG_W-1:0]           mag;
   logic [MUL_W-1:0]           prod;
   logic [CEL_W-1:0]           quot;
   logic                       neg;
   logic signed [INTERP_W-1:0] base;
   logic signed [INTERP_W-1:0] delta;
   logic signed [INTERP_W-1:0] tail;
   logic signed [INTERP_W-1:0] val;

   assign mag   = seg.offset[OFFSET_W-1] ? MAG_W'(-seg.offset) : MAG_W'(seg.offset);
   assign prod  = MUL_W'(mag) * MUL_W'(tac_pkg::seg_coef(seg.idx));
   assign quot  = prod[tac_pkg::STEP_DIV_SHIFT +: CEL_W];
   assign neg   = seg.offset[OFFSET_W-1] ^ tac_pkg::seg_falling(seg.idx);
   assign base  = $signed({{(INTERP_W-CEL_W){1'b0}},
                           tac_pkg::rom_celsius(seg.idx - IDX_W'(1))});
   assign delta = $signed({{(INTERP_W-CEL_W){1'b0}}, quot});
   assign tail  = $signed({{(INTERP_W-CEL_W){1'b0}},
                           tac_pkg::rom_celsius(IDX_W'(TABLE_USED - 1))});

   always_comb begin
      if (!seg.hit) begin
         val = tail;
      end else if (neg) begin
         val = base - delta;
      end else begin
         val = base + delta;
      end
      if (val < 0) begin
         temp = '0;
      end else if (val > INTERP_W'(tac_pkg::TEMP_MAX)) begin
         temp = TEMP_W'(tac_pkg::TEMP_MAX);
      end else begin
         temp = val[TEMP_W-1:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/thermistor_adc_to_celsius.sv */
`default_nettype none

// Thermistor converter to degrees Celsius. Takes one 10-bit sample per cycle
// on req_ and averages each group of SAMPLES_PER_READING samples, then looks
// the average up in a table of up to 20 entries (TABLE_ENTRIES) with linear interpolation and
// clamps to 0..255. A temperature transaction is issued on rsp_ only when the
// value differs from the last one reported (21 after reset). The accumulator
// is a single adder, so samples are taken every cycle; req_ready drops only
// while a finished group cannot advance because rsp_ is stalled and the four
// stage registers (group sum, average, table segment, result) are full. After
// the last sample of a group is taken, its result passes through them in turn.
module thermistor_adc_to_celsius #(
   parameter int SAMPLES_PER_READING = 5,
   parameter int TABLE_ENTRIES       = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [9:0] req_adc_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_temperature_c
);

   localparam int ADC_W      = tac_pkg::ADC_W;
   localparam int TEMP_W     = tac_pkg::TEMP_W;
   localparam int TABLE_USED = (TABLE_ENTRIES < 2) ? 2 :
                               (TABLE_ENTRIES > tac_pkg::ROM_SIZE) ? tac_pkg::ROM_SIZE :
                               TABLE_ENTRIES;
   localparam int SUM_W      = $clog2(SAMPLES_PER_READING * ((1 << ADC_W) - 1) + 1);
   localparam int CNT_W      = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam int DIV_SHIFT  = SUM_W + $clog2(SAMPLES_PER_READING);
   localparam int DIV_MULT   = ((1 << DIV_SHIFT) + SAMPLES_PER_READING - 1)
                               / SAMPLES_PER_READING;
   localparam int PROD_W     = SUM_W + DIV_SHIFT + 1;

   logic [SUM_W-1:0]  sum_ff, sum_in, sum_next;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              grp_valid_ff, grp_valid_in;
   logic [SUM_W-1:0]  grp_sum_ff, grp_sum_in;
   logic              avg_valid_ff, avg_valid_in;
   logic [ADC_W-1:0]  avg_ff, avg_in;
   logic              seg_valid_ff, seg_valid_in;
   tac_pkg::seg_type  seg_ff, seg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic [TEMP_W-1:0] last_ff, last_in;

   logic              group_end;
   logic              accept;
   logic              out_free;
   logic              seg_drop, seg_go, seg_emit;
   logic              avg_go, grp_go, grp_free;
   logic [PROD_W-1:0] avg_prod;
   logic [ADC_W-1:0]  avg_calc;
   tac_pkg::seg_type  seg_calc;
   logic [TEMP_W-1:0] temp_calc;

   tac_segment #(
      .TABLE_USED(TABLE_USED)
   ) u_segment (
      .avg(avg_ff),
      .seg(seg_calc)
   );

   tac_interp #(
      .TABLE_USED(TABLE_USED)
   ) u_interp (
      .seg (seg_ff),
      .temp(temp_calc)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign seg_drop  = temp_calc == last_ff;
   assign seg_go    = seg_valid_ff && (seg_drop || out_free);
   assign seg_emit  = seg_valid_ff && !seg_drop && out_free;
   assign avg_go    = avg_valid_ff && (!seg_valid_ff || seg_go);
   assign grp_go    = grp_valid_ff && (!avg_valid_ff || avg_go);
   assign grp_free  = !grp_valid_ff || grp_go;

   assign group_end = count_ff == CNT_W'(SAMPLES_PER_READING - 1);
   assign req_ready = !group_end || grp_free;
   assign accept    = req_valid && req_ready;
   assign sum_next  = sum_ff + SUM_W'(req_adc_sample);

   // exact truncating divide by the group size through a rounded-up reciprocal
   assign avg_prod  = PROD_W'(grp_sum_ff) * PROD_W'(DIV_MULT);
   assign avg_calc  = avg_prod[DIV_SHIFT +: ADC_W];

   always_comb begin
      sum_in       = sum_ff;
      count_in     = count_ff;
      grp_valid_in = grp_valid_ff && !grp_go;
      grp_sum_in   = grp_sum_ff;
      if (accept) begin
         if (group_end) begin
            sum_in       = '0;
            count_in     = '0;
            grp_valid_in = 1'b1;
            grp_sum_in   = sum_next;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
      avg_valid_in = grp_go || (avg_valid_ff && !avg_go);
      avg_in       = grp_go ? avg_calc : avg_ff;
      seg_valid_in = avg_go || (seg_valid_ff && !seg_go);
      seg_in       = avg_go ? seg_calc : seg_ff;
      rsp_valid_in = seg_emit || (rsp_valid_ff && !rsp_ready);
      rsp_temp_in  = seg_emit ? temp_calc : rsp_temp_ff;
      last_in      = seg_emit ? temp_calc : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         grp_valid_ff <= 1'b0;
         avg_valid_ff <= 1'b0;
         seg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= TEMP_W'(tac_pkg::RESET_TEMPERATURE);
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         grp_valid_ff <= grp_valid_in;
         avg_valid_ff <= avg_valid_in;
         seg_valid_ff <= seg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_sum_ff  <= grp_sum_in;
      avg_ff      <= avg_in;
      seg_ff      <= seg_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_temperature_c = rsp_temp_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SAMPLES_PER_READING - 1))
      else $error("sample count past group size");

   a_sum_clear: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0))
      else $error("sum not cleared at group start");

   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (grp_valid_ff && group_end && !grp_go))
      else $error("req_ready low without a blocked group");

   a_stall_chain: assert property (@(posedge clock) disable iff (reset)
      (avg_valid_ff && !avg_go) |-> (seg_valid_ff && !seg_go))
      else $error("average stage stalled behind a free stage");

   a_emit_tracks: assert property (@(posedge clock) disable iff (reset)
      seg_emit |=> (rsp_valid_ff && (last_ff == rsp_temp_ff)))
      else $error("issued temperature not recorded");
`endif

endmodule

`default_nettype wire

/* dv/tb_thermistor_adc_to_celsius.sv */
`timescale 1ns / 1ps

module tb_thermistor_adc_to_celsius;

   localparam int GROUP_LEN    = 5;
   localparam int TOTAL_ITEMS  = 900;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   localparam int CELSIUS_AT [0:tac_pkg::ROM_SIZE-1] = '{
      841, 255, 209, 184, 166, 153, 142, 132, 124, 116,
      108, 101, 93, 86, 78, 70, 61, 50, 34, 3
   };

   typedef enum int {RX_OPEN, RX_HALF, RX_TIGHT} rx_mode_type;

   class temp_scoreboard;
      int unsigned group_sum = 0;
      int unsigned group_fill = 0;
      logic [tac_pkg::TEMP_W-1:0] reported = 8'(tac_pkg::RESET_TEMPERATURE);
      logic [tac_pkg::TEMP_W-1:0] pending [$];
      int samples_in = 0;
      int groups_done = 0;
      int temps_checked = 0;
      int errors = 0;

      function int average_to_celsius(int avg);
         int c;
         int lo_adc;
         int hi_adc;
         bit found;
         c = CELSIUS_AT[tac_pkg::ROM_SIZE-1];
         found = 1'b0;
         for (int i = 1; i < tac_pkg::ROM_SIZE; i++) begin
            lo_adc = tac_pkg::ROM_ADC_BASE + tac_pkg::ROM_STEP * (i - 1);
            hi_adc = tac_pkg::ROM_ADC_BASE + tac_pkg::ROM_STEP * i;
            if (!found && hi_adc > avg) begin
               c = CELSIUS_AT[i-1] + ((avg - lo_adc) * (CELSIUS_AT[i] - CELSIUS_AT[i-1]))
                   / (hi_adc - lo_adc);
               found = 1'b1;
            end
         end
         if (c > tac_pkg::TEMP_MAX) begin
            c = tac_pkg::TEMP_MAX;
         end
         if (c < 0) begin
            c = 0;
         end
         return c;
      endfunction

      function void note_sample(logic [tac_pkg::ADC_W-1:0] s);
         int t;
         samples_in++;
         group_sum += s;
         group_fill++;
         if (group_fill < GROUP_LEN) begin
            return;
         end
         t = average_to_celsius(int'(group_sum / GROUP_LEN));
         group_sum = 0;
         group_fill = 0;
         groups_done++;
         if (t != int'(reported)) begin
            reported = t[tac_pkg::TEMP_W-1:0];
            pending.push_back(reported);
         end
      endfunction

      function void check_temp(logic [tac_pkg::TEMP_W-1:0] actual);
         logic [tac_pkg::TEMP_W-1:0] want;
         if (pending.size() == 0) begin
            $error("temperature_c: no transaction expected, actual %0d", actual);
            errors++;
            return;
         end
         want = pending.pop_front();
         temps_checked++;
         if (want !== actual) begin
            $error("temperature_c: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [9:0] req_adc_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_temperature_c;

   temp_scoreboard sb = new;
   bit long_hold_done = 1'b0;
   int cycles = 0;
   int burst_left = 0;
   logic [9:0] prev_group [GROUP_LEN];

   thermistor_adc_to_celsius DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_temperature_c (rsp_temperature_c)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_sample(req_adc_sample);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_temp(rsp_temperature_c);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stall stretches, plus one long hold-off mid-run
   initial begin
      rx_mode_type mode;
      int mode_left;
      mode = RX_OPEN;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!long_hold_done && sb.samples_in >= HOLD_AFTER) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (mode)
               RX_OPEN: begin
                  rsp_ready <= 1'b1;
               end
               RX_HALF: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   task automatic send_sample(input logic [9:0] s);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_adc_sample <= s;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_group(input logic [9:0] a, b, c, d, e);
      prev_group = '{a, b, c, d, e};
      send_sample(a);
      send_sample(b);
      send_sample(c);
      send_sample(d);
      send_sample(e);
   endtask

   function automatic logic [9:0] near(input int center, input int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) begin
         v = 0;
      end
      if (v > 1023) begin
         v = 1023;
      end
      return v[9:0];
   endfunction

   function automatic logic [9:0] edge_value();
      case ($urandom_range(0, 2))
         0: return 10'd0;
         1: return 10'd1023;
         default: return near(tac_pkg::ROM_ADC_BASE
                              + tac_pkg::ROM_STEP * $urandom_range(0, tac_pkg::ROM_SIZE - 1), 1);
      endcase
   endfunction

   task automatic random_group();
      logic [9:0] g [GROUP_LEN];
      int kind;
      int center;
      kind = $urandom_range(0, 9);
      center = $urandom_range(0, 1023);
      if (kind == 9) begin
         center = tac_pkg::ROM_ADC_BASE + tac_pkg::ROM_STEP * $urandom_range(0, tac_pkg::ROM_SIZE - 1);
      end
      for (int i = 0; i < GROUP_LEN; i++) begin
         case (kind)
            6: g[i] = prev_group[i];
            7: g[i] = 10'($urandom_range(0, 1023));
            8: g[i] = edge_value();
            9: g[i] = near(center, 1);
            default: g[i] = near(center, 20);
         endcase
      end
      send_group(g[0], g[1], g[2], g[3], g[4]);
   endtask

   initial begin
      prev_group = '{default: '0};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero average saturates high, full scale clamps to the last entry,
      // an unchanged reading, a mixed group, and an average on an entry
      send_group(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
      send_group(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
      send_group(10'd1008, 10'd1008, 10'd1008, 10'd1008, 10'd1008);
      send_group(10'd0, 10'd1023, 10'd512, 10'd1, 10'd100);
      send_group(10'd54, 10'd54, 10'd54, 10'd54, 10'd54);

      while (sb.samples_in < TOTAL_ITEMS) begin
         random_group();
      end
      req_valid <= 1'b0;

      // let the monitor record the last accepted sample first
      @(negedge clock);
      while (sb.pending.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d samples in %0d groups; %0d temperature changes checked.",
               sb.samples_in, sb.groups_done, sb.temps_checked);
      $display("Long response hold-off exercised: %0d", long_hold_done);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/tac_pkg.sv
rtl/core/tac_segment.sv
rtl/core/tac_interp.sv
rtl/core/thermistor_adc_to_celsius.sv
dv/tb_thermistor_adc_to_celsius.sv
